@@ design/tcch_pkg.sv @@
package tcch_pkg;

    // Default number of CORDIC micro-rotations
    localparam int TRIG_ITER_DEF = 16;
    localparam int ATAN_ENTRIES  = 24;

    // CORDIC gain 0.6072529350 in Q30
    localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;

    // Angles in hundredths of a degree
    localparam int FULL_TURN    = 36000;
    localparam int HALF_TURN    = 18000;
    localparam int QUARTER_TURN = 9000;
    localparam int ANGLE_SHIFT  = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 1'b1;
    localparam int CFG_DATA_W = 16;

    localparam logic [10:0] SCALE_GAIN_RST = 11'd236;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
    } t_in_req;

    typedef struct packed {
        logic        [15:0] heading;
        logic signed [15:0] scaled_x;
        logic signed [15:0] scaled_y;
        logic signed [15:0] scaled_z;
    } t_out_req;

    // round(atan(2^-i) in degrees * 6553600)
    function automatic logic signed [31:0] atan_lut(input int idx);
        logic signed [31:0] v;
        unique case (idx)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466764;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/tilt_compensated_compass_heading.sv @@
// Tilt-compensated compass heading.
// Input channel: i_in_valid / o_in_stall carry one request per cycle: raw
// magnetometer axes plus roll and pitch in hundredths of a degree. Output
// channel: o_out_valid / i_out_stall carry heading (0..35999) and the three
// gain-scaled, saturated axes. Configuration: i_cfg_we writes scale_gain
// (index 0) or declination (index 1); write only while the pipe is empty.
// The pipe has one stage per micro-rotation of the sine/cosine CORDICs,
// one per step of the atan2 CORDIC, plus scaling, sign fix, two multiply
// stages, the atan2 setup, the declination add and the output register.
// Throughput is one request per cycle while the receiver does not stall.
// Reset clears all valid bits and loads the register defaults (gain 236,
// declination 0). When the receiver stalls with a result waiting, the whole
// pipe holds and o_in_stall rises in the same cycle; nothing is dropped.
module tilt_compensated_compass_heading #(
    parameter int TRIG_ITERATIONS = tcch_pkg::TRIG_ITER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcch_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tcch_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tcch_pkg::t_in_req                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tcch_pkg::t_out_req                  o_out
);
    import tcch_pkg::*;

    localparam int N = TRIG_ITERATIONS;

    typedef enum logic [1:0] {BASE_NONE, BASE_POS, BASE_NEG} t_base;

    // saturating gain: (raw * gain) / 256 toward zero
    function automatic logic signed [15:0] scale_axis(input logic signed [15:0] raw,
                                                      input logic [10:0] g);
        logic signed [27:0] p;
        logic signed [27:0] q;
        p = raw * $signed({1'b0, g});
        if (p < 0) p = p + 28'sd255;
        q = p >>> 8;
        if (q > 28'sd32767) return 16'sh7fff;
        else if (q < -28'sd32768) return 16'sh8000;
        return q[15:0];
    endfunction

    // wrap to +-180 then fold into +-90; returns {neg, angle}
    function automatic logic [17:0] fold_angle(input logic signed [15:0] ang);
        logic signed [16:0] a;
        logic               neg;
        a   = 17'(ang);
        neg = 1'b0;
        if (a >= 17'(HALF_TURN)) a = a - 17'(FULL_TURN);
        if (a < -17'(HALF_TURN)) a = a + 17'(FULL_TURN);
        if (a > 17'(QUARTER_TURN)) begin
            a = a - 17'(HALF_TURN);
            neg = 1'b1;
        end else if (a < -17'(QUARTER_TURN)) begin
            a = a + 17'(HALF_TURN);
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    // global advance
    logic en;
    logic r_out_valid;
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // configuration registers
    logic        [10:0] r_gain;
    logic signed [15:0] r_decl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= SCALE_GAIN_RST;
            r_decl <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE_GAIN:  r_gain <= i_cfg_data[10:0];
                REG_DECLINATION: r_decl <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // rotation CORDIC stages (roll and pitch), index 0 loaded by scaling stage
    logic               r_rt_v  [0:N];
    logic signed [31:0] r_rr_x  [0:N];
    logic signed [31:0] r_rr_y  [0:N];
    logic signed [31:0] r_rr_z  [0:N];
    logic signed [31:0] r_rp_x  [0:N];
    logic signed [31:0] r_rp_y  [0:N];
    logic signed [31:0] r_rp_z  [0:N];
    logic               r_rt_nr [0:N];
    logic               r_rt_np [0:N];
    logic signed [15:0] r_rt_sx [0:N];
    logic signed [15:0] r_rt_sy [0:N];
    logic signed [15:0] r_rt_sz [0:N];

    logic [17:0] fr, fp;
    assign fr = fold_angle(i_in.roll_angle);
    assign fp = fold_angle(i_in.pitch_angle);

    // scale axes and prepare angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_v[0] <= 1'b0;
        end else if (en) begin
            r_rt_v[0] <= i_in_valid;
        end
        if (en) begin
            r_rt_sx[0] <= scale_axis(i_in.mag_x, r_gain);
            r_rt_sy[0] <= scale_axis(i_in.mag_y, r_gain);
            r_rt_sz[0] <= scale_axis(i_in.mag_z, r_gain);
            r_rr_x[0]  <= CORDIC_K_Q30;
            r_rr_y[0]  <= '0;
            r_rr_z[0]  <= 32'($signed(fr[16:0])) <<< ANGLE_SHIFT;
            r_rt_nr[0] <= fr[17];
            r_rp_x[0]  <= CORDIC_K_Q30;
            r_rp_y[0]  <= '0;
            r_rp_z[0]  <= 32'($signed(fp[16:0])) <<< ANGLE_SHIFT;
            r_rt_np[0] <= fp[17];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        logic signed [31:0] n_rr_x, n_rr_y, n_rr_z, n_rp_x, n_rp_y, n_rp_z;
        always_comb begin
            if (r_rr_z[k] >= 0) begin
                n_rr_x = r_rr_x[k] - (r_rr_y[k] >>> k);
                n_rr_y = r_rr_y[k] + (r_rr_x[k] >>> k);
                n_rr_z = r_rr_z[k] - atan_lut(k);
            end else begin
                n_rr_x = r_rr_x[k] + (r_rr_y[k] >>> k);
                n_rr_y = r_rr_y[k] - (r_rr_x[k] >>> k);
                n_rr_z = r_rr_z[k] + atan_lut(k);
            end
            if (r_rp_z[k] >= 0) begin
                n_rp_x = r_rp_x[k] - (r_rp_y[k] >>> k);
                n_rp_y = r_rp_y[k] + (r_rp_x[k] >>> k);
                n_rp_z = r_rp_z[k] - atan_lut(k);
            end else begin
                n_rp_x = r_rp_x[k] + (r_rp_y[k] >>> k);
                n_rp_y = r_rp_y[k] - (r_rp_x[k] >>> k);
                n_rp_z = r_rp_z[k] + atan_lut(k);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_v[k+1] <= 1'b0;
            end else if (en) begin
                r_rt_v[k+1] <= r_rt_v[k];
            end
            if (en) begin
                r_rr_x[k+1]  <= n_rr_x;
                r_rr_y[k+1]  <= n_rr_y;
                r_rr_z[k+1]  <= n_rr_z;
                r_rp_x[k+1]  <= n_rp_x;
                r_rp_y[k+1]  <= n_rp_y;
                r_rp_z[k+1]  <= n_rp_z;
                r_rt_nr[k+1] <= r_rt_nr[k];
                r_rt_np[k+1] <= r_rt_np[k];
                r_rt_sx[k+1] <= r_rt_sx[k];
                r_rt_sy[k+1] <= r_rt_sy[k];
                r_rt_sz[k+1] <= r_rt_sz[k];
            end
        end
    end

    // sign fix for folded angles
    logic               r_n_v;
    logic signed [31:0] r_n_cr, r_n_sr, r_n_cp, r_n_sp;
    logic signed [15:0] r_n_sx, r_n_sy, r_n_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (en) begin
            r_n_v <= r_rt_v[N];
        end
        if (en) begin
            r_n_cr <= r_rt_nr[N] ? -r_rr_x[N] : r_rr_x[N];
            r_n_sr <= r_rt_nr[N] ? -r_rr_y[N] : r_rr_y[N];
            r_n_cp <= r_rt_np[N] ? -r_rp_x[N] : r_rp_x[N];
            r_n_sp <= r_rt_np[N] ? -r_rp_y[N] : r_rp_y[N];
            r_n_sx <= r_rt_sx[N];
            r_n_sy <= r_rt_sy[N];
            r_n_sz <= r_rt_sz[N];
        end
    end

    // first multiply stage
    logic signed [63:0] srsp_full, crsp_full;
    assign srsp_full = r_n_sr * r_n_sp;
    assign crsp_full = r_n_cr * r_n_sp;

    logic               r_p_v;
    logic signed [31:0] r_p_srsp, r_p_crsp;
    logic signed [47:0] r_p_xcp, r_p_ycr, r_p_zsr;
    logic signed [15:0] r_p_sx, r_p_sy, r_p_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_n_v;
        end
        if (en) begin
            r_p_srsp <= srsp_full[61:30];
            r_p_crsp <= crsp_full[61:30];
            r_p_xcp  <= 48'(r_n_sx) * 48'(r_n_cp);
            r_p_ycr  <= 48'(r_n_sy) * 48'(r_n_cr);
            r_p_zsr  <= 48'(r_n_sz) * 48'(r_n_sr);
            r_p_sx   <= r_n_sx;
            r_p_sy   <= r_n_sy;
            r_p_sz   <= r_n_sz;
        end
    end

    // second multiply stage: horizontal projection
    logic signed [47:0] ysrsp, zcrsp;
    assign ysrsp = 48'(r_p_sy) * 48'(r_p_srsp);
    assign zcrsp = 48'(r_p_sz) * 48'(r_p_crsp);

    logic               r_q_v;
    logic signed [49:0] r_q_xh, r_q_yh;
    logic signed [15:0] r_q_sx, r_q_sy, r_q_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (en) begin
            r_q_v <= r_p_v;
        end
        if (en) begin
            r_q_xh <= 50'(r_p_xcp) + 50'(ysrsp) - 50'(zcrsp);
            r_q_yh <= 50'(r_p_ycr) + 50'(r_p_zsr);
            r_q_sx <= r_p_sx;
            r_q_sy <= r_p_sy;
            r_q_sz <= r_p_sz;
        end
    end

    // vectoring CORDIC stages, index 0 is the half-plane setup
    logic               r_ve_v    [0:N];
    logic signed [51:0] r_ve_x    [0:N];
    logic signed [51:0] r_ve_y    [0:N];
    logic signed [31:0] r_ve_z    [0:N];
    t_base              r_ve_base [0:N];
    logic               r_ve_zero [0:N];
    logic signed [15:0] r_ve_sx   [0:N];
    logic signed [15:0] r_ve_sy   [0:N];
    logic signed [15:0] r_ve_sz   [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve_v[0] <= 1'b0;
        end else if (en) begin
            r_ve_v[0] <= r_q_v;
        end
        if (en) begin
            r_ve_zero[0] <= (r_q_xh == '0) && (r_q_yh == '0);
            r_ve_z[0]    <= '0;
            if (r_q_xh < 0) begin
                r_ve_x[0]    <= -52'(r_q_xh);
                r_ve_y[0]    <= -52'(r_q_yh);
                r_ve_base[0] <= (r_q_yh >= 0) ? BASE_POS : BASE_NEG;
            end else begin
                r_ve_x[0]    <= 52'(r_q_xh);
                r_ve_y[0]    <= 52'(r_q_yh);
                r_ve_base[0] <= BASE_NONE;
            end
            r_ve_sx[0] <= r_q_sx;
            r_ve_sy[0] <= r_q_sy;
            r_ve_sz[0] <= r_q_sz;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_vec
        logic signed [51:0] n_ve_x, n_ve_y;
        logic signed [31:0] n_ve_z;
        always_comb begin
            if (r_ve_y[k] >= 0) begin
                n_ve_x = r_ve_x[k] + (r_ve_y[k] >>> k);
                n_ve_y = r_ve_y[k] - (r_ve_x[k] >>> k);
                n_ve_z = r_ve_z[k] + atan_lut(k);
            end else begin
                n_ve_x = r_ve_x[k] - (r_ve_y[k] >>> k);
                n_ve_y = r_ve_y[k] + (r_ve_x[k] >>> k);
                n_ve_z = r_ve_z[k] - atan_lut(k);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ve_v[k+1] <= 1'b0;
            end else if (en) begin
                r_ve_v[k+1] <= r_ve_v[k];
            end
            if (en) begin
                r_ve_x[k+1]    <= n_ve_x;
                r_ve_y[k+1]    <= n_ve_y;
                r_ve_z[k+1]    <= n_ve_z;
                r_ve_base[k+1] <= r_ve_base[k];
                r_ve_zero[k+1] <= r_ve_zero[k];
                r_ve_sx[k+1]   <= r_ve_sx[k];
                r_ve_sy[k+1]   <= r_ve_sy[k];
                r_ve_sz[k+1]   <= r_ve_sz[k];
            end
        end
    end

    // round atan2 to hundredths and add declination
    localparam logic signed [32:0] HALF_TURN_FX = 33'(HALF_TURN) <<< ANGLE_SHIFT;
    localparam logic signed [32:0] ROUND_HALF   = 33'sd1 <<< (ANGLE_SHIFT - 1);

    logic signed [32:0] zsum;
    logic signed [16:0] hdeg;
    always_comb begin
        unique case (r_ve_base[N])
            BASE_POS: zsum = 33'(r_ve_z[N]) + HALF_TURN_FX + ROUND_HALF;
            BASE_NEG: zsum = 33'(r_ve_z[N]) - HALF_TURN_FX + ROUND_HALF;
            default:  zsum = 33'(r_ve_z[N]) + ROUND_HALF;
        endcase
        hdeg = r_ve_zero[N] ? 17'sd0 : zsum[32:16];
    end

    logic               r_f_v;
    logic signed [17:0] r_f_h;
    logic signed [15:0] r_f_sx, r_f_sy, r_f_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_ve_v[N];
        end
        if (en) begin
            r_f_h  <= 18'(hdeg) + 18'(r_decl);
            r_f_sx <= r_ve_sx[N];
            r_f_sy <= r_ve_sy[N];
            r_f_sz <= r_ve_sz[N];
        end
    end

    // wrap into 0..35999, two passes
    logic signed [17:0] w1, w2;
    always_comb begin
        if (r_f_h < 0)                     w1 = r_f_h + 18'(FULL_TURN);
        else if (r_f_h >= 18'(FULL_TURN))  w1 = r_f_h - 18'(FULL_TURN);
        else                               w1 = r_f_h;
        if (w1 < 0)                        w2 = w1 + 18'(FULL_TURN);
        else if (w1 >= 18'(FULL_TURN))     w2 = w1 - 18'(FULL_TURN);
        else                               w2 = w1;
    end

    // output register
    t_out_req r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f_v;
        end
        if (en) begin
            r_out.heading  <= w2[15:0];
            r_out.scaled_x <= r_f_sx;
            r_out.scaled_y <= r_f_sy;
            r_out.scaled_z <= r_f_sz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
